// ----- hw/rtl/scd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  localparam int DATA_W     = 64;
  localparam int MAX_TERMS  = 3;
  localparam int NUM_RATIOS = 3;
  localparam int TC_W       = 2;
  localparam int K_W        = $clog2(MAX_TERMS + 1);
  localparam int DIV_W      = $clog2(MAX_TERMS + 2);
  // event time plus one term per step
  localparam int ACC_W      = DATA_W + $clog2(MAX_TERMS + 1);
  localparam int ADDR_W     = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TERM_COUNT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATIO_FIRST = 3'd2;

  localparam logic signed [DATA_W-1:0] S64_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S64_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0]                  origin_time;
    logic [TC_W-1:0]                           term_count;
    logic [NUM_RATIOS-1:0][DATA_W-1:0]         ratio;
  } cfg_t;

  // ceil(2^64 / d) for the divisors that are not powers of two
  function automatic logic [DATA_W-1:0] div_recip(logic [DIV_W-1:0] d);
    logic [DATA_W-1:0] r;
    unique case (d)
      3'd3:    r = 64'h5555555555555556;
      3'd5:    r = 64'h3333333333333334;
      3'd6:    r = 64'h2AAAAAAAAAAAAAAB;
      3'd7:    r = 64'h2492492492492493;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic div_is_pow2(logic [DIV_W-1:0] d);
    return (d == 3'd2) || (d == 3'd4);
  endfunction

  function automatic logic [1:0] div_shift(logic [DIV_W-1:0] d);
    logic [1:0] s;
    unique case (d)
      3'd2:    s = 2'd1;
      3'd4:    s = 2'd2;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scd_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scd_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [scd_pkg::DATA_W-1:0]    pwdata,
  output logic [scd_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  output scd_pkg::cfg_t                      cfg_o
);

  scd_pkg::cfg_t                       cfg_q;
  logic [scd_pkg::REG_IDX_W-1:0]       idx;
  logic                                wr_en;

  assign idx    = paddr[scd_pkg::ADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      if (idx == scd_pkg::REG_ORIGIN) begin
        cfg_q.origin_time <= pwdata;
      end
      if (idx == scd_pkg::REG_TERM_COUNT) begin
        cfg_q.term_count <= pwdata[scd_pkg::TC_W-1:0];
      end
      for (int i = 0; i < scd_pkg::NUM_RATIOS; i++) begin
        if (idx == scd_pkg::REG_IDX_W'(scd_pkg::REG_RATIO_FIRST + i)) begin
          cfg_q.ratio[i] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == scd_pkg::REG_ORIGIN) begin
      prdata = cfg_q.origin_time;
    end
    if (idx == scd_pkg::REG_TERM_COUNT) begin
      prdata = scd_pkg::DATA_W'(cfg_q.term_count);
    end
    for (int i = 0; i < scd_pkg::NUM_RATIOS; i++) begin
      if (idx == scd_pkg::REG_IDX_W'(scd_pkg::REG_RATIO_FIRST + i)) begin
        prdata = cfg_q.ratio[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/scd_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// floor(a * b / 2^64), signed, from four 32x32 partial products
module scd_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [scd_pkg::DATA_W-1:0]    a_i,
  input  wire logic [scd_pkg::DATA_W-1:0]    b_i,
  output logic                               done_o,
  output logic [scd_pkg::DATA_W-1:0]         hi_o
);

  localparam int HALF_W = scd_pkg::DATA_W / 2;
  localparam int PROD_W = 2 * scd_pkg::DATA_W;

  logic [scd_pkg::DATA_W-1:0] ua_q, ub_q, hi_q;
  logic                       neg_q;
  logic [PROD_W-1:0]          acc_q, acc_neg, pp_ext;
  logic [1:0]                 cnt_q;
  logic                       run_q, fin_q, done_q;
  logic [HALF_W-1:0]          a_half, b_half;
  logic [scd_pkg::DATA_W-1:0] pp;
  logic [7:0]                 sh;

  // cnt: a0b0, a0b1, a1b0, a1b1
  assign a_half  = cnt_q[1] ? ua_q[scd_pkg::DATA_W-1:HALF_W] : ua_q[HALF_W-1:0];
  assign b_half  = cnt_q[0] ? ub_q[scd_pkg::DATA_W-1:HALF_W] : ub_q[HALF_W-1:0];
  assign pp      = a_half * b_half;
  assign sh      = 8'(HALF_W) * (8'(cnt_q[0]) + 8'(cnt_q[1]));
  assign pp_ext  = {{scd_pkg::DATA_W{1'b0}}, pp} << sh;
  assign acc_neg = ~acc_q + PROD_W'(1);

  assign done_o = done_q;
  assign hi_o   = hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= run_q && (cnt_q == 2'd3);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[scd_pkg::DATA_W-1] ? (~a_i + scd_pkg::DATA_W'(1)) : a_i;
      ub_q  <= b_i[scd_pkg::DATA_W-1] ? (~b_i + scd_pkg::DATA_W'(1)) : b_i;
      neg_q <= a_i[scd_pkg::DATA_W-1] ^ b_i[scd_pkg::DATA_W-1];
      acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + pp_ext;
    end
    if (fin_q) begin
      hi_q <= neg_q ? acc_neg[PROD_W-1:scd_pkg::DATA_W] : acc_q[PROD_W-1:scd_pkg::DATA_W];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/spin_down_time_correction_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// each term takes two passes of the shared 64x64 multiplier (four 32x32 steps each);
// the divide by 3 takes one more pass and a remainder fix step; one item at a time
// throughput: a new item is taken once busy_o falls, in the cycle the result is strobed
// result is flagged by done_o, high for one cycle, and held on the ports until the next; the receiver cannot stall it
// reset is asynchronous active low and clears the sequencer and all config registers
module spin_down_time_correction_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [63:0]            event_time_i,
  output logic                               done_o,
  output logic signed [63:0]                 corrected_time_o,
  output logic                               saturated_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [scd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [scd_pkg::DATA_W-1:0]    pwdata,
  output logic [scd_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int DW = scd_pkg::DATA_W;
  localparam int AW = scd_pkg::ACC_W;
  localparam int RW = DW + 4;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DIFF     = 10'b0000000010,
    S_FD_GO    = 10'b0000000100,
    S_FD_WAIT  = 10'b0000001000,
    S_DIV_GO   = 10'b0000010000,
    S_DIV_WAIT = 10'b0000100000,
    S_DIV_FIX  = 10'b0001000000,
    S_RF_GO    = 10'b0010000000,
    S_RF_WAIT  = 10'b0100000000,
    S_OUT      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  scd_pkg::cfg_t cfg;

  logic [DW-1:0]                 ev_q, ev_d, d_q, d_d, f_q, f_d, t_q, t_d;
  logic [AW-1:0]                 acc_q, acc_d;
  logic                          sat_q, sat_d;
  logic [scd_pkg::K_W-1:0]       k_q, k_d, n_q, n_d;
  logic                          done_q, done_d, osat_q, osat_d;
  logic [DW-1:0]                 res_q, res_d;

  logic                          mul_start, mul_done;
  logic [DW-1:0]                 mul_a, mul_b, mul_hi;
  logic [scd_pkg::DIV_W-1:0]     divisor;
  logic [DW:0]                   diff;
  logic [RW-1:0]                 f_ext, qd, rem;
  logic [scd_pkg::K_W-1:0]       ridx;
  logic [AW-DW:0]                acc_top;

  scd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .hi_o    (mul_hi)
  );

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign corrected_time_o = res_q;
  assign saturated_o      = osat_q;

  assign divisor = scd_pkg::DIV_W'(k_q) + scd_pkg::DIV_W'(1);
  assign ridx    = k_q - scd_pkg::K_W'(1);
  assign diff    = {ev_q[DW-1], ev_q} - {cfg.origin_time[DW-1], cfg.origin_time};
  // remainder of the reciprocal estimate, one step of correction either way
  assign f_ext   = {{(RW-DW){f_q[DW-1]}}, f_q};
  assign qd      = (divisor[0] ? f_ext : '0) + (divisor[1] ? (f_ext << 1) : '0) +
                   (divisor[2] ? (f_ext << 2) : '0);
  assign rem     = {{(RW-DW){t_q[DW-1]}}, t_q} - qd;
  assign acc_top = acc_q[AW-1:DW-1];

  assign mul_start = (state_q == S_FD_GO) || (state_q == S_DIV_GO) || (state_q == S_RF_GO);

  always_comb begin
    mul_a = f_q;
    mul_b = d_q;
    unique case (state_q)
      S_DIV_GO: begin
        mul_a = t_q;
        mul_b = scd_pkg::div_recip(divisor);
      end
      S_RF_GO: begin
        mul_a = cfg.ratio[ridx[$clog2(scd_pkg::NUM_RATIOS)-1:0]];
        mul_b = f_q;
      end
      default: begin
        mul_a = f_q;
        mul_b = d_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    ev_d    = ev_q;
    d_d     = d_q;
    f_d     = f_q;
    t_d     = t_q;
    acc_d   = acc_q;
    sat_d   = sat_q;
    k_d     = k_q;
    n_d     = n_q;
    done_d  = 1'b0;
    osat_d  = osat_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ev_d    = event_time_i;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        if (diff[DW] != diff[DW-1]) begin
          d_d   = diff[DW] ? scd_pkg::S64_MIN : scd_pkg::S64_MAX;
          f_d   = diff[DW] ? scd_pkg::S64_MIN : scd_pkg::S64_MAX;
          sat_d = 1'b1;
        end else begin
          d_d   = diff[DW-1:0];
          f_d   = diff[DW-1:0];
          sat_d = 1'b0;
        end
        acc_d = {{(AW-DW){ev_q[DW-1]}}, ev_q};
        n_d   = (int'(cfg.term_count) > scd_pkg::MAX_TERMS) ?
                scd_pkg::K_W'(scd_pkg::MAX_TERMS) : scd_pkg::K_W'(cfg.term_count);
        k_d   = scd_pkg::K_W'(1);
        state_d = (n_d == '0) ? S_OUT : S_FD_GO;
      end
      S_FD_GO: begin
        state_d = S_FD_WAIT;
      end
      S_FD_WAIT: begin
        if (mul_done) begin
          if (scd_pkg::div_is_pow2(divisor)) begin
            f_d     = $signed(mul_hi) >>> scd_pkg::div_shift(divisor);
            state_d = S_RF_GO;
          end else begin
            t_d     = mul_hi;
            state_d = S_DIV_GO;
          end
        end
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (mul_done) begin
          f_d     = mul_hi;
          state_d = S_DIV_FIX;
        end
      end
      S_DIV_FIX: begin
        if (rem[RW-1]) begin
          f_d = f_q - DW'(1);
        end else if (rem[RW-2:0] >= (RW-1)'(divisor)) begin
          f_d = f_q + DW'(1);
        end
        state_d = S_RF_GO;
      end
      S_RF_GO: begin
        state_d = S_RF_WAIT;
      end
      S_RF_WAIT: begin
        if (mul_done) begin
          acc_d = acc_q + {{(AW-DW){mul_hi[DW-1]}}, mul_hi};
          if (k_q == n_q) begin
            state_d = S_OUT;
          end else begin
            k_d     = k_q + scd_pkg::K_W'(1);
            state_d = S_FD_GO;
          end
        end
      end
      S_OUT: begin
        done_d = 1'b1;
        if ((&acc_top) || (~|acc_top)) begin
          res_d  = acc_q[DW-1:0];
          osat_d = sat_q;
        end else begin
          res_d  = acc_q[AW-1] ? scd_pkg::S64_MIN : scd_pkg::S64_MAX;
          osat_d = 1'b1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    d_q    <= d_d;
    f_q    <= f_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    sat_q  <= sat_d;
    k_q    <= k_d;
    n_q    <= n_d;
    osat_q <= osat_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire
